// File: hdl/dvru_pkg.sv
// Shared field widths for the distance-vector route update block.
// No dependencies; imported by distance_vector_route_update.
package dvru_pkg;

	localparam int ADDR_W   = 32;  // subnet address
	localparam int PFX_W    = 6;   // prefix length
	localparam int NIC_IN_W = 2;   // interface index on the ports
	localparam int MET_IN_W = 5;   // metric on the ports
	localparam int TAG_W    = 32;  // update tag

endpackage

// File: hdl/distance_vector_route_update.sv
// Distance-vector routing table update: flat exact-match subnet table with
// per-interface distances, best-route selection and advertisement output.
// Depends on dvru_pkg for the port field widths.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   upd     | upd_valid/upd_ready  | subnet_address, prefix_length, arrival_nic,
//           |                      | neighbor_metric, update_tag
//   adv     | adv_valid/adv_ready  | adv_address, adv_prefix_length, adv_nic,
//           |                      | adv_metric, adv_tag, withdrawn, table_full
//
// One update is taken every cycle unless a held result waits on adv_ready; its
// advertisement, if any, passes the input register, then the result register, and is
// offered from the result register until adv_ready takes it.
// Every table entry is its own cell: the match and the minimum over its
// distance vector run in all cells at once within the stage-one cycle.
// Reset clears all entry valid bits; no clearing pass is needed.
// A held result stalls the input register only while adv_ready is low.
module distance_vector_route_update
	import dvru_pkg::*;
#(
	parameter int TABLE_ENTRIES   = 64,
	parameter int NIC_COUNT       = 4,
	parameter int METRIC_INFINITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd_valid,
	output logic                upd_ready,
	input  logic [ADDR_W-1:0]   subnet_address,
	input  logic [PFX_W-1:0]    prefix_length,
	input  logic [NIC_IN_W-1:0] arrival_nic,
	input  logic [MET_IN_W-1:0] neighbor_metric,
	input  logic [TAG_W-1:0]    update_tag,
	output logic                adv_valid,
	input  logic                adv_ready,
	output logic [ADDR_W-1:0]   adv_address,
	output logic [PFX_W-1:0]    adv_prefix_length,
	output logic [NIC_IN_W-1:0] adv_nic,
	output logic [MET_IN_W-1:0] adv_metric,
	output logic [TAG_W-1:0]    adv_tag,
	output logic                withdrawn,
	output logic                table_full
);

	localparam int NIC_W = $clog2(NIC_COUNT);
	localparam int DW    = $clog2(METRIC_INFINITY + 1);
	localparam int SW    = ((DW > MET_IN_W) ? DW : MET_IN_W) + 1;
	localparam logic [DW-1:0] INF_D = DW'(METRIC_INFINITY);
	localparam logic [SW-1:0] INF_S = SW'(METRIC_INFINITY);

	// Stage one: input register.
	logic                v_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [PFX_W-1:0]    pfx_s1;
	logic [NIC_IN_W-1:0] nic_s1;
	logic [MET_IN_W-1:0] metric_s1;
	logic [TAG_W-1:0]    tag_s1;

	// Result register.
	logic                adv_valid_q;
	logic [ADDR_W-1:0]   adv_address_q;
	logic [PFX_W-1:0]    adv_prefix_q;
	logic [NIC_IN_W-1:0] adv_nic_q;
	logic [MET_IN_W-1:0] adv_metric_q;
	logic [TAG_W-1:0]    adv_tag_q;
	logic                withdrawn_q;
	logic                table_full_q;

	// One-hot mark of the lowest free slot, zero when the table is full.
	logic [TABLE_ENTRIES-1:0] free_oh_q;

	logic                     s1_go;
	logic                     nic_ok;
	logic                     live;
	logic [SW-1:0]            metric_sum;
	logic [DW-1:0]            arr_dist;
	logic [NIC_W-1:0]         nic_idx;
	logic                     hit_any;
	logic                     free_any;
	logic                     do_insert;
	logic [TABLE_ENTRIES-1:0] hit_c;
	logic [TABLE_ENTRIES-1:0] reach_c;
	logic [TABLE_ENTRIES-1:0] chg_c;
	logic [TABLE_ENTRIES-1:0] valid_d;
	logic [DW-1:0]            best_c [TABLE_ENTRIES];
	logic [NIC_W-1:0]         bnic_c [TABLE_ENTRIES];
	logic                     sel_reach;
	logic                     sel_chg;
	logic [DW-1:0]            sel_best;
	logic [NIC_W-1:0]         sel_bnic;
	logic                     res_valid;
	logic [NIC_IN_W-1:0]      res_nic;
	logic [MET_IN_W-1:0]      res_metric;
	logic                     res_wd;
	logic                     res_full;

	assign s1_go     = v_s1 && (!adv_valid_q || adv_ready);
	assign upd_ready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (upd_valid && upd_ready) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_valid && upd_ready) begin
			addr_s1   <= subnet_address;
			pfx_s1    <= prefix_length;
			nic_s1    <= arrival_nic;
			metric_s1 <= neighbor_metric;
			tag_s1    <= update_tag;
		end
	end

	assign nic_ok     = 32'(nic_s1) < 32'(NIC_COUNT);
	assign nic_idx    = NIC_W'(nic_s1);
	assign live       = SW'(metric_s1) < INF_S;
	assign metric_sum = SW'(metric_s1) + SW'(1);
	assign arr_dist   = (metric_sum >= INF_S) ? INF_D : DW'(metric_sum);
	assign hit_any    = |hit_c;
	assign free_any   = |free_oh_q;
	assign do_insert  = !hit_any && live && free_any;

	for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_entry
		logic             valid_q;
		logic [ADDR_W-1:0] addr_q;
		logic [PFX_W-1:0] pfx_q;
		logic [DW-1:0]    dist_q [NIC_COUNT];
		logic [NIC_W-1:0] fwd_q;
		logic [DW-1:0]    upd_dist [NIC_COUNT];
		logic [DW-1:0]    best;
		logic [NIC_W-1:0] bnic;
		logic             reach;
		logic             hit;
		logic             ins;
		logic             valid_nx;

		assign hit = valid_q && (addr_q == addr_s1) && (pfx_q == pfx_s1);
		assign ins = free_oh_q[e] && do_insert;

		// Minimum over the updated vector; a strict compare keeps the lowest index.
		always_comb begin
			for (int n = 0; n < NIC_COUNT; n++) begin
				upd_dist[n] = (NIC_W'(n) == nic_idx) ? arr_dist : dist_q[n];
			end
			best  = INF_D;
			bnic  = '0;
			reach = 1'b0;
			for (int n = 0; n < NIC_COUNT; n++) begin
				if (upd_dist[n] < best) begin
					best  = upd_dist[n];
					bnic  = NIC_W'(n);
					reach = 1'b1;
				end
			end
		end

		always_comb begin
			valid_nx = valid_q;
			if (s1_go && nic_ok) begin
				if (ins) begin
					valid_nx = 1'b1;
				end else if (hit && !reach) begin
					valid_nx = 1'b0;
				end
			end
		end

		assign hit_c[e]   = hit;
		assign reach_c[e] = reach;
		assign chg_c[e]   = (bnic != fwd_q) || (best != dist_q[fwd_q]);
		assign best_c[e]  = best;
		assign bnic_c[e]  = bnic;
		assign valid_d[e] = valid_nx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q <= 1'b0;
			end else begin
				valid_q <= valid_nx;
			end
		end

		always_ff @(posedge clk) begin
			if (s1_go && nic_ok) begin
				if (ins) begin
					addr_q <= addr_s1;
					pfx_q  <= pfx_s1;
					for (int n = 0; n < NIC_COUNT; n++) begin
						dist_q[n] <= (NIC_W'(n) == nic_idx) ? arr_dist : INF_D;
					end
					fwd_q <= nic_idx;
				end else if (hit) begin
					dist_q[nic_idx] <= arr_dist;
					if (reach) begin
						fwd_q <= bnic;
					end
				end
			end
		end
	end

	// Lowest zero of the next valid vector, ready for the following beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_oh_q <= TABLE_ENTRIES'(1);
		end else begin
			free_oh_q <= ~valid_d & (valid_d + TABLE_ENTRIES'(1));
		end
	end

	// Subnets are unique in the table, so at most one cell hits.
	always_comb begin
		sel_reach = 1'b0;
		sel_chg   = 1'b0;
		sel_best  = '0;
		sel_bnic  = '0;
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			sel_reach = sel_reach | (hit_c[e] & reach_c[e]);
			sel_chg   = sel_chg | (hit_c[e] & chg_c[e]);
			sel_best  = sel_best | (hit_c[e] ? best_c[e] : '0);
			sel_bnic  = sel_bnic | (hit_c[e] ? bnic_c[e] : '0);
		end
	end

	always_comb begin
		res_valid  = 1'b0;
		res_nic    = '0;
		res_metric = MET_IN_W'(METRIC_INFINITY);
		res_wd     = 1'b0;
		res_full   = 1'b0;
		if (nic_ok) begin
			if (hit_any) begin
				if (!sel_reach) begin
					res_valid = 1'b1;
					res_wd    = 1'b1;
				end else if (sel_chg) begin
					res_valid  = 1'b1;
					res_nic    = NIC_IN_W'(sel_bnic);
					res_metric = MET_IN_W'(sel_best);
				end
			end else if (live) begin
				res_valid = 1'b1;
				if (free_any) begin
					res_nic    = nic_s1;
					res_metric = MET_IN_W'(arr_dist);
				end else begin
					res_full = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_valid_q <= 1'b0;
		end else if (s1_go && res_valid) begin
			adv_valid_q <= 1'b1;
		end else if (adv_ready) begin
			adv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			adv_address_q <= addr_s1;
			adv_prefix_q  <= pfx_s1;
			adv_nic_q     <= res_nic;
			adv_metric_q  <= res_metric;
			adv_tag_q     <= tag_s1;
			withdrawn_q   <= res_wd;
			table_full_q  <= res_full;
		end
	end

	assign adv_valid         = adv_valid_q;
	assign adv_address       = adv_address_q;
	assign adv_prefix_length = adv_prefix_q;
	assign adv_nic           = adv_nic_q;
	assign adv_metric        = adv_metric_q;
	assign adv_tag           = adv_tag_q;
	assign withdrawn         = withdrawn_q;
	assign table_full        = table_full_q;

endmodule
